// ===== hdl/bezier_patch_subdivider_macros.svh =====
// Assertion macros for the Bezier patch subdivider.
`ifndef BEZIER_PATCH_SUBDIVIDER_MACROS_SVH
`define BEZIER_PATCH_SUBDIVIDER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bps_pkg.sv =====
// Shared types, constants and helper functions of the Bezier patch subdivider.
package bps_pkg;

    localparam int MAX_DEPTH   = 3;
    localparam int COORD_WIDTH = 20;
    localparam int FIELD_W     = 20;
    localparam int EXTRA_FRAC  = 9;
    localparam int INT_W       = COORD_WIDTH + EXTRA_FRAC;
    localparam int NUM_POINTS  = 16;
    localparam int PT_W        = 4;
    localparam int REGION_W    = 3;
    localparam int LVL_ENTRIES = (MAX_DEPTH + 2) * NUM_POINTS;
    localparam int LVL_ADDR_W  = REGION_W + PT_W;
    localparam int FACE_W      = 2 * MAX_DEPTH;
    localparam int DEPTH_W     = 2;
    localparam int CORNER_W    = 60;
    localparam int FACE_NUM_W  = 6;
    localparam int CP_W        = 3 * COORD_WIDTH;

    localparam logic [REGION_W-1:0] TMP_REGION = REGION_W'(MAX_DEPTH + 1);
    localparam logic [PT_W-1:0]     LAST_INDEX = PT_W'(NUM_POINTS - 1);

    typedef logic [INT_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef point_t [3:0] quad_pts_t;

    typedef struct packed {
        logic [PT_W-1:0]    point_index;
        logic [FIELD_W-1:0] coord_x;
        logic [FIELD_W-1:0] coord_y;
        logic [FIELD_W-1:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic [CORNER_W-1:0]   corner_first;
        logic [CORNER_W-1:0]   corner_second;
        logic [CORNER_W-1:0]   corner_third;
        logic [CORNER_W-1:0]   corner_fourth;
        logic [FACE_NUM_W-1:0] face_number;
        logic                  last_face;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_GRP_RD,
        ST_GRP_WR,
        ST_FACE_RD
    } state_t;

    // Widen a Q16.4 coordinate to the internal Q16.13 format.
    function automatic coord_t to_int(logic [COORD_WIDTH-1:0] raw);
        return {raw, {EXTRA_FRAC{1'b0}}};
    endfunction

    // Floor an internal coordinate back to Q16.4.
    function automatic logic [COORD_WIDTH-1:0] to_q4(coord_t v);
        return v[INT_W-1:EXTRA_FRAC];
    endfunction

    // Pack a point as x, y, z from the top bits down.
    function automatic logic [CORNER_W-1:0] pack_corner(point_t p);
        return CORNER_W'({to_q4(p.x), to_q4(p.y), to_q4(p.z)});
    endfunction

    // Sub-patch point that makes face corner c.
    function automatic logic [PT_W-1:0] corner_pt(logic [1:0] c);
        logic [PT_W-1:0] pt;
        unique case (c)
            2'd0:    pt = PT_W'(0);
            2'd1:    pt = PT_W'(12);
            2'd2:    pt = PT_W'(15);
            default: pt = PT_W'(3);
        endcase
        return pt;
    endfunction

    // Index of the final face for a given depth.
    function automatic logic [FACE_W-1:0] face_top(logic [DEPTH_W-1:0] d);
        return FACE_W'((1 << (2 * int'(d))) - 1);
    endfunction

    // First level whose quadrant digit changed when the face counter became f.
    function automatic logic [DEPTH_W-1:0] start_level(logic [FACE_W-1:0] f,
                                                       logic [DEPTH_W-1:0] d);
        logic [DEPTH_W-1:0] lvl;
        logic               stop;
        lvl  = d;
        stop = 1'b0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (!stop && (i + 1) < int'(d) && f[2*i +: 2] == 2'd0) begin
                lvl = lvl - DEPTH_W'(1);
            end
            else begin
                stop = 1'b1;
            end
        end
        return lvl;
    endfunction

endpackage

// ===== hdl/bps_split4.sv =====
// One de Casteljau midpoint split of four points, all three coordinates.
module bps_split4
    import bps_pkg::*;
(
    input  quad_pts_t pts,
    input  logic      half,
    output quad_pts_t res
);

    typedef coord_t [3:0] cquad_t;

    // floor((a+b)/2) on two's complement values
    function automatic coord_t avg2(coord_t a, coord_t b);
        logic [INT_W:0] s;
        s = {a[INT_W-1], a} + {b[INT_W-1], b};
        return s[INT_W:1];
    endfunction

    function automatic cquad_t split_c(cquad_t q, logic h);
        coord_t a1, hm, s2, a2, s1, m;
        cquad_t r;
        a1 = avg2(q[0], q[1]);
        hm = avg2(q[1], q[2]);
        s2 = avg2(q[2], q[3]);
        a2 = avg2(a1, hm);
        s1 = avg2(hm, s2);
        m  = avg2(a2, s1);
        if (!h) begin
            r = {m, a2, a1, q[0]};
        end
        else begin
            r = {q[3], s2, s1, m};
        end
        return r;
    endfunction

    cquad_t qx, qy, qz, rx, ry, rz;

    // Gather each coordinate, split, scatter back
    always_comb
    begin
        for (int i = 0; i < 4; i++) begin
            qx[i] = pts[i].x;
            qy[i] = pts[i].y;
            qz[i] = pts[i].z;
        end
        rx = split_c(qx, half);
        ry = split_c(qy, half);
        rz = split_c(qz, half);
        for (int i = 0; i < 4; i++) begin
            res[i].x = rx[i];
            res[i].y = ry[i];
            res[i].z = rz[i];
        end
    end

endmodule

// ===== hdl/bezier_patch_subdivider.sv =====
// Top level of the bicubic Bezier patch subdivider: sequencer, point and level memories.
//
// Load the 16 control points one beat per cycle while busy is low. The beat that
// carries point 15 starts the subdivision when the configured depth is not zero; busy
// then stays high until the final face has been strobed. The run copies the points
// into level memory, then each split level takes eight four-point groups through the
// single-port-read level memory. For every face only the levels from the first changed
// quadrant digit down are recomputed, followed by the corner reads. Each face appears
// on result for exactly one cycle with result_valid high; the receiver cannot stall it.
module bezier_patch_subdivider
    import bps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  in_item_t            item,
    input  logic                cfg_we,
    input  logic [DEPTH_W-1:0]  cfg_data,
    output logic                result_valid,
    output result_t             result
);

`include "bezier_patch_subdivider_macros.svh"

    state_t                 state_reg, state_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic [1:0]             grp_reg, grp_next;
    logic                   pass_reg, pass_next;
    logic [DEPTH_W-1:0]     lvl_reg, lvl_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [DEPTH_W-1:0]     cfg_depth_reg;
    logic [FACE_W-1:0]      face_reg, face_next;
    logic                   result_valid_reg, result_valid_next;
    result_t                result_reg, result_next;
    quad_pts_t              buf_reg, buf_next;
    quad_pts_t              res_reg, res_next;
    point_t [2:0]           corner_reg, corner_next;

    logic [CP_W-1:0]        cp_mem [NUM_POINTS];
    logic [CP_W-1:0]        cp_rdata_reg;
    logic [PT_W-1:0]        cp_raddr;

    point_t                 lv_mem [LVL_ENTRIES];
    point_t                 lv_rdata_reg;
    logic [LVL_ADDR_W-1:0]  lv_raddr, lv_waddr;
    logic                   lv_we;
    point_t                 lv_wdata;

    logic                   accept, launch, face_last, split_last;
    logic [DEPTH_W-1:0]     run_depth;
    logic [2:0]             quad_sh;
    logic [FACE_W-1:0]      quad_bits;
    logic                   half;
    quad_pts_t              split_out;
    logic [1:0]             sub;
    logic [1:0]             prev;

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign run_depth    = (cfg_depth_reg > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
                                                                : cfg_depth_reg;
    assign launch       = accept && (item.point_index == LAST_INDEX) &&
                          (run_depth != '0);
    assign face_last    = (face_reg == face_top(depth_reg));
    assign split_last   = pass_reg && (lvl_reg == depth_reg);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign sub          = cnt_reg[1:0];
    assign prev         = 2'(cnt_reg - 5'd1);

    // Pick this level's quadrant digit, then the half for this pass
    assign quad_sh   = {1'b0, 2'(depth_reg - lvl_reg)} << 1;
    assign quad_bits = face_reg >> quad_sh;
    assign half      = pass_reg ? quad_bits[0] : quad_bits[1];

    bps_split4 u_split (
        .pts  (buf_reg),
        .half (half),
        .res  (split_out)
    );

    // Hold the depth register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_depth_reg <= DEPTH_W'(MAX_DEPTH);
        end
        else if (cfg_we) begin
            cfg_depth_reg <= cfg_data;
        end
    end

    // Control point memory: write on each accepted beat, registered read
    always_ff @(posedge clk)
    begin
        if (accept) begin
            cp_mem[item.point_index] <= {item.coord_x[COORD_WIDTH-1:0],
                                         item.coord_y[COORD_WIDTH-1:0],
                                         item.coord_z[COORD_WIDTH-1:0]};
        end
        cp_rdata_reg <= cp_mem[cp_raddr];
    end

    // Level memory: levels 0..MAX_DEPTH plus one scratch region, registered read
    always_ff @(posedge clk)
    begin
        if (lv_we) begin
            lv_mem[lv_waddr] <= lv_wdata;
        end
        lv_rdata_reg <= lv_mem[lv_raddr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (launch) state_next = ST_COPY;
            end
            ST_COPY:
            begin
                if (cnt_reg == 5'd16) state_next = ST_GRP_RD;
            end
            ST_GRP_RD:
            begin
                if (cnt_reg == 5'd5) state_next = ST_GRP_WR;
            end
            ST_GRP_WR:
            begin
                if (cnt_reg == 5'd3) begin
                    state_next = (grp_reg == 2'd3 && split_last) ? ST_FACE_RD : ST_GRP_RD;
                end
            end
            ST_FACE_RD:
            begin
                if (cnt_reg == 5'd4) state_next = face_last ? ST_IDLE : ST_GRP_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Counters, memory access and datapath loads
    always_comb
    begin
        cnt_next          = cnt_reg + 5'd1;
        grp_next          = grp_reg;
        pass_next         = pass_reg;
        lvl_next          = lvl_reg;
        depth_next        = depth_reg;
        face_next         = face_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        buf_next          = buf_reg;
        res_next          = res_reg;
        corner_next       = corner_reg;
        cp_raddr          = cnt_reg[PT_W-1:0];
        lv_raddr          = '0;
        lv_waddr          = '0;
        lv_we             = 1'b0;
        lv_wdata          = res_reg[sub];
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (launch) begin
                    depth_next = run_depth;
                    face_next  = '0;
                    lvl_next   = DEPTH_W'(1);
                    pass_next  = 1'b0;
                    grp_next   = '0;
                end
            end
            ST_COPY:
            begin
                // Widen each stored point into level 0 in the cycle after its registered read
                if (cnt_reg != 5'd0) begin
                    lv_we    = 1'b1;
                    lv_waddr = {REGION_W'(0), PT_W'(cnt_reg - 5'd1)};
                    lv_wdata = '{x: to_int(cp_rdata_reg[3*COORD_WIDTH-1:2*COORD_WIDTH]),
                                 y: to_int(cp_rdata_reg[2*COORD_WIDTH-1:COORD_WIDTH]),
                                 z: to_int(cp_rdata_reg[COORD_WIDTH-1:0])};
                end
                if (cnt_reg == 5'd16) cnt_next = '0;
            end
            ST_GRP_RD:
            begin
                // Rows of the previous level, or columns of the scratch region
                if (!pass_reg) begin
                    lv_raddr = {REGION_W'(2'(lvl_reg - DEPTH_W'(1))), grp_reg, sub};
                end
                else begin
                    lv_raddr = {TMP_REGION, sub, grp_reg};
                end
                if (cnt_reg >= 5'd1 && cnt_reg <= 5'd4) buf_next[prev] = lv_rdata_reg;
                if (cnt_reg == 5'd5) begin
                    res_next = split_out;
                    cnt_next = '0;
                end
            end
            ST_GRP_WR:
            begin
                lv_we = 1'b1;
                if (!pass_reg) begin
                    lv_waddr = {TMP_REGION, grp_reg, sub};
                end
                else begin
                    lv_waddr = {REGION_W'(lvl_reg), sub, grp_reg};
                end
                if (cnt_reg == 5'd3) begin
                    cnt_next = '0;
                    grp_next = grp_reg + 2'd1;
                    if (grp_reg == 2'd3) begin
                        if (!pass_reg) begin
                            pass_next = 1'b1;
                        end
                        else begin
                            pass_next = 1'b0;
                            lvl_next  = lvl_reg + DEPTH_W'(1);
                        end
                    end
                end
            end
            ST_FACE_RD:
            begin
                lv_raddr = {REGION_W'(depth_reg), corner_pt(sub)};
                if (cnt_reg >= 5'd1 && cnt_reg <= 5'd3) corner_next[prev] = lv_rdata_reg;
                if (cnt_reg == 5'd4) begin
                    // Issue the face beat and advance the face counter
                    result_valid_next         = 1'b1;
                    result_next.corner_first  = pack_corner(corner_reg[0]);
                    result_next.corner_second = pack_corner(corner_reg[1]);
                    result_next.corner_third  = pack_corner(corner_reg[2]);
                    result_next.corner_fourth = pack_corner(lv_rdata_reg);
                    result_next.face_number   = FACE_NUM_W'(face_reg);
                    result_next.last_face     = face_last;
                    cnt_next                  = '0;
                    grp_next                  = '0;
                    pass_next                 = 1'b0;
                    if (face_last) begin
                        face_next = '0;
                    end
                    else begin
                        face_next = face_reg + FACE_W'(1);
                        lvl_next  = start_level(face_reg + FACE_W'(1), depth_reg);
                    end
                end
            end
            default: cnt_next = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            grp_reg          <= '0;
            pass_reg         <= 1'b0;
            lvl_reg          <= DEPTH_W'(1);
            depth_reg        <= DEPTH_W'(MAX_DEPTH);
            face_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            grp_reg          <= grp_next;
            pass_reg         <= pass_next;
            lvl_reg          <= lvl_next;
            depth_reg        <= depth_next;
            face_reg         <= face_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        buf_reg    <= buf_next;
        res_reg    <= res_next;
        corner_reg <= corner_next;
    end

    `BPS_ASSERT_NOW(a_last_ends_run, result_valid && result.last_face, !busy, "busy after last face")
    `BPS_ASSERT_NOW(a_mid_face_busy, result_valid && !result.last_face, busy, "idle mid patch")
    `BPS_ASSERT_NOW(a_idle_face_zero, state_reg == ST_IDLE, face_reg == '0, "face count not cleared")
    `BPS_ASSERT_NEXT(a_launch_copy, launch, state_reg == ST_COPY && cnt_reg == 5'd0, "no copy start")

endmodule
